// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; take in by `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held
`define KIBR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset
`define KIBR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ----- src/kibr_pkg.sv -----
// Shared types and constants of the key integer bucket router.
// No dependencies; imported by every module of the block but the checker.
package kibr_pkg;

    localparam int MAX_INT_POSITION  = 5;
    localparam int BUCKET_INDEX_BITS = 20;

    localparam int POS_W    = 3;
    localparam int STEP_W   = 32;
    localparam int BUCKET_W = 21;
    localparam int VALUE_W  = 63;
    localparam int CNT_W    = 6;

    // value at or above which one more digit could overflow 63 bits
    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 63'd922337203685477580;
    localparam logic [7:0]         CHAR_TILDE  = 8'h7E;
    localparam logic [7:0]         CHAR_ZERO   = 8'h30;
    localparam logic [7:0]         CHAR_NINE   = 8'h39;

    // configuration register indexes
    localparam logic [1:0] CFG_INT_POSITION = 2'd0;
    localparam logic [1:0] CFG_STEP_DIVISOR = 2'd1;
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

    typedef enum logic [2:0] {
        PH_SEG_START,
        PH_SEEK,
        PH_DIGITS,
        PH_AFTER_TILDE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic [POS_W-1:0]    int_position;
        logic [STEP_W-1:0]   step_divisor;
        logic [BUCKET_W-1:0] bucket_count;
    } cfg_t;

    // one finished key handed from parser to arithmetic
    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } job_t;

endpackage

// ----- src/kibr_front.sv -----
// Key parser: takes one key byte a beat, tracks digit runs and hands a job
// per key to the queue. Depends on kibr_pkg.
module kibr_front import kibr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] key_byte
    input  logic       s_tlast,   // last_byte
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   found_reg, found_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               seg_reg, seg_next;
    logic               err_reg, err_next;

    logic               digit;
    logic [VALUE_W-1:0] value_plus;
    logic               value_high;
    logic [POS_W-1:0]   tpos;
    logic [POS_W-1:0]   found_inc;
    logic               reached;
    logic               beat;
    logic               ok;

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;
    assign q_push   = beat && s_tlast;
    assign q_job    = '{ok: ok, value: value_next};

    // position clamp: zero means one, large values saturate
    always_comb begin
        tpos = cfg.int_position;
        if (cfg.int_position == '0) begin
            tpos = POS_W'(1);
        end else if (cfg.int_position > POS_W'(MAX_INT_POSITION)) begin
            tpos = POS_W'(MAX_INT_POSITION);
        end
    end

    // digit append: value * 10 + d
    assign digit      = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign value_high = value_reg >= VALUE_LIMIT;
    assign value_plus = (value_reg << 3) + (value_reg << 1)
                        + VALUE_W'(s_tdata[3:0]);
    assign found_inc  = found_reg + POS_W'(1);
    assign reached    = {1'b0, found_inc} >= {1'b0, tpos};

    // parser next state for the current byte
    always_comb begin
        phase_next = phase_reg;
        found_next = found_reg;
        value_next = value_reg;
        seg_next   = seg_reg;
        err_next   = err_reg;
        if (!err_reg) begin
            case (phase_reg)
                PH_SEG_START, PH_SEEK: begin
                    if (digit) begin
                        seg_next   = (phase_reg == PH_SEG_START);
                        value_next = VALUE_W'(s_tdata[3:0]);
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_SEEK;
                    end
                end
                PH_DIGITS: begin
                    if (digit) begin
                        if (value_high) err_next = 1'b1;
                        else value_next = value_plus;
                    end else if (seg_reg && s_tdata == CHAR_TILDE) begin
                        seg_next   = 1'b0;
                        value_next = '0;
                        phase_next = PH_AFTER_TILDE;
                    end else begin
                        // number ends here
                        found_next = found_inc;
                        if (reached) begin
                            phase_next = PH_DONE;
                        end else begin
                            value_next = '0;
                            phase_next = seg_reg ? PH_SEG_START : PH_SEEK;
                            seg_next   = 1'b0;
                        end
                    end
                end
                PH_AFTER_TILDE: begin
                    if (digit) begin
                        if (value_high) err_next = 1'b1;
                        else value_next = value_plus;
                        phase_next = PH_DIGITS;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                default: phase_next = PH_DONE;
            endcase
        end
    end

    // a key ending inside the target number also counts
    always_comb begin
        ok = 1'b0;
        if (!err_next) begin
            if (phase_next == PH_DONE) begin
                ok = 1'b1;
            end else if (phase_next == PH_DIGITS) begin
                ok = {1'b0, found_next} + 4'd1 >= {1'b0, tpos};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEG_START;
            found_reg <= '0;
            value_reg <= '0;
            seg_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else if (beat) begin
            if (s_tlast) begin
                phase_reg <= PH_SEG_START;
                found_reg <= '0;
                value_reg <= '0;
                seg_reg   <= 1'b0;
                err_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                found_reg <= found_next;
                value_reg <= value_next;
                seg_reg   <= seg_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ----- src/kibr_queue.sv -----
// Two-entry job queue between parser and arithmetic unit.
// Depends on kibr_pkg.
module kibr_queue import kibr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- src/kibr_back.sv -----
// Bit-serial divide by step and modulo by bucket count, with output register.
// Quotient bits feed the modulo as they appear. Depends on kibr_pkg.
module kibr_back import kibr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_not_empty,
    input  job_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] bucket_index, [23:20] zero
    output logic        m_tuser    // no_target
);

    back_state_t state_reg, state_next;

    logic [VALUE_W-1:0]  div_reg;
    logic [STEP_W-1:0]   r1_reg;
    logic [BUCKET_W-1:0] r2_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ok_reg;

    logic                             out_valid_reg;
    logic [BUCKET_INDEX_BITS-1:0]     out_bucket_reg;
    logic                             out_nt_reg;

    logic                load_job;
    logic                step_en;
    logic                load_out;
    logic                out_free;

    logic [STEP_W:0]     t1;
    logic                ge1;
    logic                qbit;
    logic [STEP_W-1:0]   r1_new;
    logic [BUCKET_W-1:0] bdiv;
    logic [BUCKET_W:0]   t2;
    logic                ge2;
    logic [BUCKET_W-1:0] r2_new;

    assign out_free = !out_valid_reg || m_tready;

    // one restoring step of each: divide, then reduce the quotient bit
    assign t1     = {r1_reg, div_reg[VALUE_W-1]};
    assign ge1    = t1 >= {1'b0, cfg.step_divisor};
    assign r1_new = ge1 ? STEP_W'(t1 - {1'b0, cfg.step_divisor}) : t1[STEP_W-1:0];
    assign qbit   = (cfg.step_divisor == '0) ? div_reg[VALUE_W-1] : ge1;
    assign bdiv   = (cfg.bucket_count == '0) ? BUCKET_W'(1) : cfg.bucket_count;
    assign t2     = {r2_reg, qbit};
    assign ge2    = t2 >= {1'b0, bdiv};
    assign r2_new = ge2 ? BUCKET_W'(t2 - {1'b0, bdiv}) : t2[BUCKET_W-1:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        load_job   = 1'b0;
        step_en    = 1'b0;
        load_out   = 1'b0;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    load_job   = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                step_en = 1'b1;
                if (cnt_reg == '0) state_next = BK_HOLD;
            end
            BK_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= BK_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (load_job) begin
            div_reg <= q_head.value;
            ok_reg  <= q_head.ok;
            r1_reg  <= '0;
            r2_reg  <= '0;
            cnt_reg <= CNT_W'(VALUE_W - 1);
        end else if (step_en) begin
            div_reg <= div_reg << 1;
            r1_reg  <= r1_new;
            r2_reg  <= r2_new;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_bucket_reg <= ok_reg ? r2_reg[BUCKET_INDEX_BITS-1:0] : '0;
            out_nt_reg     <= !ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_bucket_reg};
    assign m_tuser  = out_nt_reg;

endmodule

// ----- src/key_integer_bucket_router.sv -----
// Top level of the key integer bucket router: configuration registers,
// parser, job queue and arithmetic unit. Depends on kibr_pkg and submodules.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[7:0] key_byte, s_tlast last_byte
//  m_       out  m_tvalid/m_tready  m_tdata[19:0] bucket_index, m_tuser no_target
//  cfg_     in   cfg_valid/cfg_ready cfg_index[1:0], cfg_data[31:0]
//
// The parser takes one byte a cycle. Each key then passes through the
// bit-serial divide and modulo unit, which works on one key at a time
// and sets the key rate. Two finished keys can wait in the queue, so the
// parser stalls only when the queue is full. Reset is synchronous and
// needs no clearing pass; cfg_ready is always high.
module key_integer_bucket_router import kibr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] bucket_index, [23:20] zero
    output logic        m_tuser,   // no_target
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_not_empty;
    job_t q_job, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.int_position <= POS_W'(1);
            cfg_reg.step_divisor <= '0;
            cfg_reg.bucket_count <= BUCKET_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INT_POSITION: cfg_reg.int_position <= cfg_data[POS_W-1:0];
                CFG_STEP_DIVISOR: cfg_reg.step_divisor <= cfg_data[STEP_W-1:0];
                CFG_BUCKET_COUNT: cfg_reg.bucket_count <= cfg_data[BUCKET_W-1:0];
                default: ;
            endcase
        end
    end

    kibr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    kibr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    kibr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- src/kibr_checker.sv -----
// Port-level checks of the key integer bucket router, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kibr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a result beat stays offered until taken
    `KIBR_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    // a missing target always reports bucket zero
    `KIBR_ASSERT(a_nt_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[19:0] == 20'd0)
    // padding bits of the result stay clear
    `KIBR_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[23:20] == 4'd0)
    // no result straight out of reset
    `KIBR_ASSERT_ALWAYS(a_rst_quiet, aclk, !aresetn |=> !m_tvalid)

endmodule

bind key_integer_bucket_router kibr_checker u_kibr_checker (.*);
